// ===== hdl/mi3_pkg.sv =====
// Shared constants and types for the 3x3 matrix inverse block.
// Holds the number format, the internal widths and the queue entry layout.
// Depends on nothing.
package mi3_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    localparam int W   = DATA_WIDTH;
    localparam int PW  = 2 * W;
    localparam int CW  = 2 * W + 1;
    localparam int DW  = 3 * W + 2;
    localparam int NB  = CW + 2 * FRAC_BITS + 1;
    localparam int NW  = ((NB > DW) ? NB : DW) + 1;
    localparam int SW  = DW + 1 + W;
    localparam int XW  = ((NW > SW) ? NW : SW) + 1;

    localparam int QD  = 8;
    localparam int QAW = $clog2(QD);
    localparam int FS  = 6;

    typedef struct packed {
        logic [8:0][CW-1:0] mag;
        logic [8:0]         cneg;
        logic [DW-1:0]      dmag;
        logic               dneg;
        logic               sing;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_qitem;

    typedef struct packed {
        logic [8:0][XW-1:0] rem;
        logic [8:0][W-1:0]  q;
        logic [8:0]         neg;
        logic [8:0]         big;
        logic [DW:0]        d2;
        logic               sing;
    } t_div;

endpackage

// ===== hdl/mi3_front.sv =====
// Front end: accepts matrices, forms cofactors and the determinant exactly,
// and classifies sign, magnitude and singularity for the queue.
// Depends on mi3_pkg.
module mi3_front (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  logic [8:0][mi3_pkg::W-1:0]             i_m,
    input  logic [mi3_pkg::QAW:0]                  i_qcnt,
    output logic                                   o_ready,
    output mi3_pkg::t_qitem                        o_push
);
    localparam int W  = mi3_pkg::W;
    localparam int PW = mi3_pkg::PW;
    localparam int CW = mi3_pkg::CW;
    localparam int DW = mi3_pkg::DW;
    localparam int FS = mi3_pkg::FS;

    logic [FS-1:0]              r_v;
    logic [$clog2(FS+1)-1:0]    w_inflight;
    logic [mi3_pkg::QAW+1:0]    w_total;
    logic                       w_acc;

    logic signed [PW-1:0] r_p1 [9];
    logic signed [PW-1:0] r_p2 [9];
    logic signed [CW-1:0] r_c2 [9];
    logic signed [CW-1:0] r_c3 [9];
    logic signed [CW-1:0] r_c4 [9];
    logic signed [CW-1:0] r_c5 [9];
    logic signed [W-1:0]  r_a1 [3];
    logic signed [W-1:0]  r_a2 [3];
    logic signed [CW-1:0] r_ph [3];
    logic signed [CW-1:0] r_pl [3];
    logic signed [DW-1:0] r_t  [3];
    logic signed [DW-1:0] r_det;
    mi3_pkg::t_entry      r_e6;

    assign w_inflight = $clog2(FS+1)'($countones(r_v));
    assign w_total    = (mi3_pkg::QAW+2)'(i_qcnt) + (mi3_pkg::QAW+2)'(w_inflight);
    assign o_ready    = (w_total < (mi3_pkg::QAW+2)'(mi3_pkg::QD));
    assign w_acc      = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[FS-2:0], w_acc};
        end
    end

    genvar j;
    generate
        for (j = 0; j < 9; j++) begin : g_cof
            localparam int K  = j / 3;
            localparam int V  = j % 3;
            localparam int XC = (V + 1) % 3;
            localparam int YC = (V + 2) % 3;
            localparam int P  = (K + 1) % 3;
            localparam int R  = (K + 2) % 3;
            always_ff @(posedge i_clk) begin
                r_p1[j] <= $signed(i_m[3*XC+P]) * $signed(i_m[3*YC+R]);
                r_p2[j] <= $signed(i_m[3*XC+R]) * $signed(i_m[3*YC+P]);
                r_c2[j] <= $signed({r_p1[j][PW-1], r_p1[j]}) - $signed({r_p2[j][PW-1], r_p2[j]});
                r_c3[j] <= r_c2[j];
                r_c4[j] <= r_c3[j];
                r_c5[j] <= r_c4[j];
                r_e6.cneg[j] <= r_c5[j][CW-1];
                r_e6.mag[j]  <= r_c5[j][CW-1] ? CW'(-r_c5[j]) : CW'(r_c5[j]);
            end
        end
        for (j = 0; j < 3; j++) begin : g_det
            logic signed [W:0] w_hi;
            logic signed [W:0] w_lo;
            assign w_hi = $signed(r_c2[3*j][CW-1:W]);
            assign w_lo = $signed({1'b0, r_c2[3*j][W-1:0]});
            always_ff @(posedge i_clk) begin
                r_a1[j] <= $signed(i_m[j]);
                r_a2[j] <= r_a1[j];
                r_ph[j] <= r_a2[j] * w_hi;
                r_pl[j] <= r_a2[j] * w_lo;
                r_t[j]  <= (DW'(r_ph[j]) <<< W) + DW'(r_pl[j]);
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        r_det     <= r_t[0] + r_t[1] + r_t[2];
        r_e6.dneg <= r_det[DW-1];
        r_e6.dmag <= r_det[DW-1] ? DW'(-r_det) : DW'(r_det);
        r_e6.sing <= (r_det == '0);
    end

    assign o_push.valid = r_v[FS-1];
    assign o_push.entry = r_e6;

endmodule

// ===== hdl/mi3_queue.sv =====
// Short request queue between the front end and the divider back end.
// Flop storage with a combinational head; depends on mi3_pkg.
module mi3_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  mi3_pkg::t_qitem         i_push,
    input  logic                    i_pop,
    output mi3_pkg::t_qitem         o_head,
    output logic [mi3_pkg::QAW:0]   o_cnt
);
    localparam int QAW = mi3_pkg::QAW;

    mi3_pkg::t_entry  r_mem [mi3_pkg::QD];
    logic [QAW-1:0]   r_wp;
    logic [QAW-1:0]   r_rp;
    logic [QAW:0]     r_cnt;
    logic             w_pop;

    assign w_pop = i_pop && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push.valid) r_wp <= r_wp + 1'b1;
            if (w_pop)        r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QAW+1)'(i_push.valid) - (QAW+1)'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) r_mem[r_wp] <= i_push.entry;
    end

    assign o_head.valid = (r_cnt != '0);
    assign o_head.entry = r_mem[r_rp];
    assign o_cnt        = r_cnt;

endmodule

// ===== hdl/mi3_back.sv =====
// Back end: rounding setup, one quotient bit per stage for all nine elements,
// then saturation and the output register. Depends on mi3_pkg.
module mi3_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mi3_pkg::t_qitem             i_head,
    output logic                        o_pop,
    input  logic                        i_ready,
    output logic                        o_valid,
    output logic [8:0][mi3_pkg::W-1:0]  o_inv,
    output logic                        o_sing,
    output logic                        o_ovf
);
    localparam int W  = mi3_pkg::W;
    localparam int XW = mi3_pkg::XW;
    localparam int F  = mi3_pkg::FRAC_BITS;

    logic                  w_en;
    logic [W:0]            r_sv;
    logic                  r_ov;
    mi3_pkg::t_div         r_st [W+1];
    mi3_pkg::t_div         n_st [W+1];
    logic [8:0][W-1:0]     n_inv;
    logic                  n_ovf;
    logic [8:0][W-1:0]     r_inv;
    logic                  r_sing;
    logic                  r_ovf;

    assign w_en  = !r_ov || i_ready;
    assign o_pop = w_en && i_head.valid;

    always_comb begin
        logic [XW-1:0] v_n;
        n_st[0].d2   = {i_head.entry.dmag, 1'b0};
        n_st[0].sing = i_head.entry.sing;
        n_st[0].q    = '0;
        for (int j = 0; j < 9; j++) begin
            v_n = (XW'(i_head.entry.mag[j]) << (2 * F + 1)) + XW'(i_head.entry.dmag);
            n_st[0].rem[j] = v_n;
            n_st[0].big[j] = (v_n >= (XW'(n_st[0].d2) << W));
            n_st[0].neg[j] = i_head.entry.cneg[j] ^ i_head.entry.dneg;
        end
    end

    genvar s;
    generate
        for (s = 1; s <= W; s++) begin : g_div
            localparam int K = W - s;
            always_comb begin
                logic [XW-1:0] v_d;
                n_st[s] = r_st[s-1];
                v_d = XW'(r_st[s-1].d2) << K;
                for (int j = 0; j < 9; j++) begin
                    if (r_st[s-1].rem[j] >= v_d) begin
                        n_st[s].rem[j]  = r_st[s-1].rem[j] - v_d;
                        n_st[s].q[j][K] = 1'b1;
                    end
                end
            end
        end
    endgenerate

    always_comb begin
        logic [W-1:0] v_lim;
        logic [W-1:0] v_m;
        logic         v_sat;
        n_ovf = 1'b0;
        for (int j = 0; j < 9; j++) begin
            v_lim = r_st[W].neg[j] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            v_sat = r_st[W].big[j] || (r_st[W].q[j] > v_lim);
            v_m   = v_sat ? v_lim : r_st[W].q[j];
            if (r_st[W].sing) begin
                n_inv[j] = '0;
            end else begin
                n_inv[j] = r_st[W].neg[j] ? W'(-v_m) : v_m;
                n_ovf    = n_ovf | v_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= '0;
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_sv <= {r_sv[W-1:0], o_pop};
            r_ov <= r_sv[W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i <= W; i++) r_st[i] <= n_st[i];
            r_inv  <= n_inv;
            r_sing <= r_st[W].sing;
            r_ovf  <= n_ovf;
        end
    end

    assign o_valid = r_ov;
    assign o_inv   = r_inv;
    assign o_sing  = r_sing;
    assign o_ovf   = r_ovf;

endmodule

// ===== hdl/matrix_inverse_3x3_top.sv =====
// 3x3 matrix inverse in signed Q16.16, adjugate over determinant.
// Channels: input matrix (i_valid / o_ready), result (o_valid / i_ready).
// Nine 32-bit elements in, given as three columns; nine elements out in
// the same column order, plus singular and overflow flags.
// Throughput: one matrix per cycle while the receiver takes results.
// Path from acceptance to o_valid: six front stages of multiplies and wide adds,
// one queue slot, one setup stage, one quotient bit per stage in the divider,
// then the output register.
// The front never stalls; it accepts only while the eight-deep queue has room
// for every matrix already in flight, so input can still be accepted after the
// receiver stops taking results, until the queue fills and o_ready drops.
// A stalled result holds in the output register and the divider freezes.
// A zero determinant returns zeros with singular set and overflow clear.
// Reset empties the pipeline and queue; no result is pending after it.
// Depends on mi3_pkg, mi3_front, mi3_queue, mi3_back.
module matrix_inverse_3x3_top (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [mi3_pkg::W-1:0]   i_m_c1_x,
    input  logic [mi3_pkg::W-1:0]   i_m_c1_y,
    input  logic [mi3_pkg::W-1:0]   i_m_c1_z,
    input  logic [mi3_pkg::W-1:0]   i_m_c2_x,
    input  logic [mi3_pkg::W-1:0]   i_m_c2_y,
    input  logic [mi3_pkg::W-1:0]   i_m_c2_z,
    input  logic [mi3_pkg::W-1:0]   i_m_c3_x,
    input  logic [mi3_pkg::W-1:0]   i_m_c3_y,
    input  logic [mi3_pkg::W-1:0]   i_m_c3_z,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [mi3_pkg::W-1:0]   o_inv_c1_x,
    output logic [mi3_pkg::W-1:0]   o_inv_c1_y,
    output logic [mi3_pkg::W-1:0]   o_inv_c1_z,
    output logic [mi3_pkg::W-1:0]   o_inv_c2_x,
    output logic [mi3_pkg::W-1:0]   o_inv_c2_y,
    output logic [mi3_pkg::W-1:0]   o_inv_c2_z,
    output logic [mi3_pkg::W-1:0]   o_inv_c3_x,
    output logic [mi3_pkg::W-1:0]   o_inv_c3_y,
    output logic [mi3_pkg::W-1:0]   o_inv_c3_z,
    output logic                    o_singular,
    output logic                    o_overflow
);
    logic [8:0][mi3_pkg::W-1:0]  w_m;
    logic [8:0][mi3_pkg::W-1:0]  w_inv;
    mi3_pkg::t_qitem             w_push;
    mi3_pkg::t_qitem             w_head;
    logic [mi3_pkg::QAW:0]       w_qcnt;
    logic                        w_pop;

    assign w_m = {i_m_c3_z, i_m_c3_y, i_m_c3_x, i_m_c2_z, i_m_c2_y, i_m_c2_x,
                  i_m_c1_z, i_m_c1_y, i_m_c1_x};

    mi3_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_m     (w_m),
        .i_qcnt  (w_qcnt),
        .o_ready (o_ready),
        .o_push  (w_push)
    );

    mi3_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_cnt   (w_qcnt)
    );

    mi3_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .i_ready (i_ready),
        .o_valid (o_valid),
        .o_inv   (w_inv),
        .o_sing  (o_singular),
        .o_ovf   (o_overflow)
    );

    assign o_inv_c1_x = w_inv[0];
    assign o_inv_c1_y = w_inv[1];
    assign o_inv_c1_z = w_inv[2];
    assign o_inv_c2_x = w_inv[3];
    assign o_inv_c2_y = w_inv[4];
    assign o_inv_c2_z = w_inv[5];
    assign o_inv_c3_x = w_inv[6];
    assign o_inv_c3_y = w_inv[7];
    assign o_inv_c3_z = w_inv[8];

    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.valid |-> (w_qcnt < (mi3_pkg::QAW+1)'(mi3_pkg::QD)) || w_pop)
        else $error("request pushed into a full queue");

    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_singular) |-> (w_inv == '0) && !o_overflow)
        else $error("singular result with nonzero elements or overflow");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head.valid)
        else $error("queue popped while empty");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid && $stable(w_inv))
        else $error("stalled result dropped or changed");

endmodule

// ===== test/inverse_checker.sv =====
// Checker for the 3x3 matrix inverse: watches both channels, predicts each
// inverse from the accepted request and compares it with the result channel.
// Depends on mi3_pkg for the element width and the fraction bits.
`timescale 1ns / 1ps

module inverse_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  i_ready_in,
    input  logic [mi3_pkg::W-1:0] i_elem [9],
    input  logic                  i_res_valid,
    input  logic                  i_res_ready,
    input  logic [mi3_pkg::W-1:0] i_res_elem [9],
    input  logic                  i_singular,
    input  logic                  i_overflow,
    output int                    o_fail_count,
    output int                    o_pending
);
    typedef logic signed [191:0] t_wide;

    typedef struct {
        logic [mi3_pkg::W-1:0] elem [9];
        logic                  singular;
        logic                  overflow;
    } t_inverse;

    t_inverse inverse_q[$];

    function automatic logic [mi3_pkg::W-1:0] rounded_quotient(t_wide cof, t_wide det,
                                                               ref logic ovf);
        logic           neg;
        t_wide          n;
        t_wide          d;
        logic [191:0]   q;
        logic [191:0]   lim;
        neg = (cof < 0) != (det < 0);
        n   = (cof < 0) ? -cof : cof;
        d   = (det < 0) ? -det : det;
        q   = ((n <<< (2 * mi3_pkg::FRAC_BITS + 1)) + d) / (d <<< 1);
        lim = neg ? (192'd1 << (mi3_pkg::W - 1)) : ((192'd1 << (mi3_pkg::W - 1)) - 1);
        if (q > lim) begin
            q   = lim;
            ovf = 1'b1;
        end
        if (neg) q = -q;
        return q[mi3_pkg::W-1:0];
    endfunction

    function automatic t_inverse predict_inverse(logic [mi3_pkg::W-1:0] m [9]);
        t_wide    a [3];
        t_wide    b [3];
        t_wide    c [3];
        t_wide    bc [3];
        t_wide    ca [3];
        t_wide    ab [3];
        t_wide    det;
        t_inverse r;
        logic     ovf;
        int       p;
        int       s;
        ovf = 1'b0;
        for (int k = 0; k < 3; k++) begin
            a[k] = t_wide'($signed(m[k]));
            b[k] = t_wide'($signed(m[3 + k]));
            c[k] = t_wide'($signed(m[6 + k]));
        end
        for (int k = 0; k < 3; k++) begin
            p = (k + 1) % 3;
            s = (k + 2) % 3;
            bc[k] = b[p] * c[s] - b[s] * c[p];
            ca[k] = c[p] * a[s] - c[s] * a[p];
            ab[k] = a[p] * b[s] - a[s] * b[p];
        end
        det = a[0] * bc[0] + a[1] * bc[1] + a[2] * bc[2];
        if (det == 0) begin
            for (int k = 0; k < 9; k++) r.elem[k] = '0;
            r.singular = 1'b1;
            r.overflow = 1'b0;
            return r;
        end
        for (int k = 0; k < 3; k++) begin
            r.elem[3 * k]     = rounded_quotient(bc[k], det, ovf);
            r.elem[3 * k + 1] = rounded_quotient(ca[k], det, ovf);
            r.elem[3 * k + 2] = rounded_quotient(ab[k], det, ovf);
        end
        r.singular = 1'b0;
        r.overflow = ovf;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_inverse want;
        int       errs;
        errs = 0;
        if (!i_rst_n) begin
            inverse_q.delete();
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            if (i_valid && i_ready_in) inverse_q.push_back(predict_inverse(i_elem));
            if (i_res_valid && i_res_ready) begin
                if (inverse_q.size() == 0) begin
                    $display("%0t: result with no request pending", $time);
                    errs = errs + 1;
                end else begin
                    want = inverse_q.pop_front();
                    for (int k = 0; k < 9; k++)
                        if (i_res_elem[k] !== want.elem[k]) begin
                            $display("%0t: element %0d expected %h actual %h",
                                     $time, k, want.elem[k], i_res_elem[k]);
                            errs = errs + 1;
                        end
                    if (i_singular !== want.singular || i_overflow !== want.overflow) begin
                        $display("%0t: flags sing/ovf expected %b%b actual %b%b", $time,
                                 want.singular, want.overflow, i_singular, i_overflow);
                        errs = errs + 1;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
            o_pending    <= inverse_q.size();
        end
    end
endmodule

// ===== test/testbench.sv =====
// Top of the 3x3 matrix inverse test: drives requests with random gaps and
// result stalls, and gives the verdict. Depends on matrix_inverse_3x3_top,
// inverse_checker and mi3_pkg.
`timescale 1ns / 1ps

module testbench;
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  i_ready = 1'b0;
    logic                  o_ready;
    logic                  o_valid;
    logic                  o_singular;
    logic                  o_overflow;
    logic [mi3_pkg::W-1:0] mat [9];
    logic [mi3_pkg::W-1:0] inv [9];
    int                    fail_count;
    int                    pending;
    int                    sent = 0;
    logic                  quiet = 1'b0;

    always #1 i_clk = ~i_clk;

    initial for (int k = 0; k < 9; k++) mat[k] = '0;

    matrix_inverse_3x3_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_m_c1_x(mat[0]), .i_m_c1_y(mat[1]), .i_m_c1_z(mat[2]),
        .i_m_c2_x(mat[3]), .i_m_c2_y(mat[4]), .i_m_c2_z(mat[5]),
        .i_m_c3_x(mat[6]), .i_m_c3_y(mat[7]), .i_m_c3_z(mat[8]),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_inv_c1_x(inv[0]), .o_inv_c1_y(inv[1]), .o_inv_c1_z(inv[2]),
        .o_inv_c2_x(inv[3]), .o_inv_c2_y(inv[4]), .o_inv_c2_z(inv[5]),
        .o_inv_c3_x(inv[6]), .o_inv_c3_y(inv[7]), .o_inv_c3_z(inv[8]),
        .o_singular(o_singular), .o_overflow(o_overflow)
    );

    inverse_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_ready_in(o_ready),
        .i_elem(mat), .i_res_valid(o_valid), .i_res_ready(i_ready),
        .i_res_elem(inv), .i_singular(o_singular), .i_overflow(o_overflow),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver stalls in bursts
    always @(negedge i_clk) begin
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_ready = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_ready = 1'b1;
    end

    task automatic send_request(logic [mi3_pkg::W-1:0] m [9]);
        if (!quiet && $urandom_range(0, 6) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        for (int k = 0; k < 9; k++) mat[k] = m[k];
        i_valid = 1'b1;
        while (!o_ready) @(negedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic send_diag(logic [mi3_pkg::W-1:0] d0, logic [mi3_pkg::W-1:0] d1,
                             logic [mi3_pkg::W-1:0] d2);
        logic [mi3_pkg::W-1:0] m [9];
        for (int k = 0; k < 9; k++) m[k] = '0;
        m[0] = d0;
        m[4] = d1;
        m[8] = d2;
        send_request(m);
    endtask

    task automatic send_fill(logic [mi3_pkg::W-1:0] v);
        logic [mi3_pkg::W-1:0] m [9];
        for (int k = 0; k < 9; k++) m[k] = v;
        send_request(m);
    endtask

    task automatic send_random(int kind);
        logic [mi3_pkg::W-1:0] m [9];
        for (int k = 0; k < 9; k++)
            case (kind)
                0:       m[k] = $urandom;
                1:       m[k] = $urandom_range(0, 1 << 19) - (1 << 18);
                2:       m[k] = $urandom_range(0, 600) - 300;
                default: m[k] = $urandom_range(0, 1 << 13) - (1 << 12);
            endcase
        if (kind == 1)
            for (int k = 0; k < 3; k++) m[4 * k] = m[4 * k] + 32'h0008_0000;
        if (kind == 3)
            for (int k = 0; k < 3; k++) m[6 + k] = m[k] + m[3 + k];
        send_request(m);
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        send_diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send_diag(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000);
        send_diag(32'h0002_0000, 32'h0000_4000, 32'hFFFC_0000);
        send_diag(32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
        send_diag(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001);
        send_diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_diag(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001);
        send_diag(32'h0000_0003, 32'h0001_0000, 32'h0001_0000);
        send_diag(32'h0001_0000, 32'h0000_0000, 32'h0001_0000);
        send_fill(32'h0000_0000);
        send_fill(32'hFFFF_FFFF);
        send_fill(32'h7FFF_FFFF);
        send_fill(32'h8000_0000);
        send_fill(32'h5555_5555);
        send_fill(32'hAAAA_AAAA);
        for (int k = 0; k < 4; k++) send_random(k);
        for (int n = 0; n < 1330; n++) begin
            if (n == 600) begin
                i_valid = 1'b0;
                while (pending != 0 || o_valid) @(negedge i_clk);
            end
            if (n == 1150) quiet = 1'b1;
            send_random($urandom_range(0, 9) < 3 ? 0 : $urandom_range(1, 3));
        end
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
        if (fail_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    initial begin
        #2000000;
        $display("testbench: done, errors");
        $finish;
    end
endmodule
